>>> hdl/ksq_pkg.sv
`default_nettype none

package ksq_pkg;

   // one table entry
   typedef struct packed {
      logic [31:0] stamp;
      logic        was_down;
      logic        released;
      logic        latch;
   } entry_type;

   localparam int MODE_W = 3;
   localparam int KEY_W  = 9;
   localparam int TIME_W = 32;
   localparam int THR_W  = 16;
   localparam int CSR_IDX_W = 2;

   localparam int REQ_TDATA_W = 48;
   localparam int RSP_TDATA_W = 8;

   // operation codes
   localparam logic [MODE_W-1:0] MODE_KEY_MSG    = 3'd0;
   localparam logic [MODE_W-1:0] MODE_QUERY      = 3'd1;
   localparam logic [MODE_W-1:0] MODE_JUST_PRESS = 3'd2;
   localparam logic [MODE_W-1:0] MODE_JUST_REL   = 3'd3;
   localparam logic [MODE_W-1:0] MODE_CLEAR      = 3'd4;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] REG_MAX_DOWN   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_LONG_DOWN  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] REG_RECENT_WIN = 2'd2;

   localparam logic [THR_W-1:0] MAX_DOWN_RST   = 16'd5000;
   localparam logic [THR_W-1:0] LONG_DOWN_RST  = 16'd500;
   localparam logic [THR_W-1:0] RECENT_WIN_RST = 16'd100;

endpackage

`default_nettype wire

>>> hdl/key_state_table_qualifier.sv
`default_nettype none

// Key state table qualifier. Keeps one entry per key (time stamp, previous-down
// flag, released flag, just-pressed latch) in an on-chip table of KEY_COUNT
// entries. The request's tuser selects the operation: key message, plain query,
// just-pressed query, just-released query or clear entry; every request gives
// exactly one response. Requests are taken one per clock while the response
// output is not stalled: the table is read at acceptance (with a bypass of the
// write landing in the same cycle), the entry is updated and written back when
// stage 1 advances, and the response is registered there. After reset the
// block runs a clearing pass, one entry per clock, with req_tready low; csr
// writes are taken at any time. Elapsed time is now_ms minus the stamp, modulo
// 2^32, so tick wrap is harmless. Keys at or above KEY_COUNT leave the table
// untouched and report all flags low.
module key_state_table_qualifier
   import ksq_pkg::*;
#(
   parameter int KEY_COUNT = 256
) (
   input  wire                    clock,
   input  wire                    reset,
   // request: tuser = mode[2:0]
   // tdata = key[8:0], now_ms[40:9], was_down_before[41], is_released[42],
   //         exclusive[43], zero[47:44]
   input  wire                    req_tvalid,
   output logic                   req_tready,
   input  wire [REQ_TDATA_W-1:0]  req_tdata,
   input  wire [MODE_W-1:0]       req_tuser,
   // response tdata = key_in_range[0], key_down[1], key_down_long[2],
   //                  just_pressed[3], just_released[4], zero[7:5]
   output logic                   rsp_tvalid,
   input  wire                    rsp_tready,
   output logic [RSP_TDATA_W-1:0] rsp_tdata,
   // register writes
   input  wire                    csr_valid,
   output logic                   csr_ready,
   input  wire [CSR_IDX_W-1:0]    csr_index,
   input  wire [THR_W-1:0]        csr_data
);

   localparam int IDX_W = (KEY_COUNT > 1) ? $clog2(KEY_COUNT) : 1;

   // ---------------- configuration ----------------
   logic [THR_W-1:0] max_down_ff, long_down_ff, recent_win_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         max_down_ff   <= MAX_DOWN_RST;
         long_down_ff  <= LONG_DOWN_RST;
         recent_win_ff <= RECENT_WIN_RST;
      end else if (csr_valid) begin
         unique case (csr_index)
            REG_MAX_DOWN:   max_down_ff   <= csr_data;
            REG_LONG_DOWN:  long_down_ff  <= csr_data;
            REG_RECENT_WIN: recent_win_ff <= csr_data;
            default: ;  // no register here
         endcase
      end
   end

   // ---------------- clearing pass after reset ----------------
   logic             clr_busy_ff, clr_busy_in;
   logic [IDX_W-1:0] clr_cnt_ff, clr_cnt_in;

   always_comb begin
      clr_busy_in = clr_busy_ff;
      clr_cnt_in  = clr_cnt_ff;
      if (clr_busy_ff) begin
         clr_cnt_in = clr_cnt_ff + 1'b1;
         if (clr_cnt_ff == IDX_W'(KEY_COUNT - 1))
            clr_busy_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_busy_ff <= 1'b1;
         clr_cnt_ff  <= '0;
      end else begin
         clr_busy_ff <= clr_busy_in;
         clr_cnt_ff  <= clr_cnt_in;
      end
   end

   // ---------------- request decode ----------------
   logic [KEY_W-1:0]  req_key;
   logic [TIME_W-1:0] req_now;
   logic [IDX_W-1:0]  req_idx;
   logic              req_accept;

   assign req_key = req_tdata[8:0];
   assign req_now = req_tdata[40:9];
   assign req_idx = req_key[IDX_W-1:0];

   // stage 1: the accepted request plus its table entry
   logic              s1_valid_ff, s1_valid_in;
   logic [MODE_W-1:0] s1_mode_ff;
   logic [IDX_W-1:0]  s1_idx_ff;
   logic              s1_in_range_ff;
   logic [TIME_W-1:0] s1_now_ff;
   logic              s1_wdb_ff, s1_rel_ff, s1_excl_ff;
   entry_type         rd_entry_ff;

   logic s1_advance;

   assign s1_advance = s1_valid_ff && (!rsp_tvalid || rsp_tready);
   assign req_tready = !clr_busy_ff && (!s1_valid_ff || s1_advance);
   assign req_accept = req_tvalid && req_tready;
   assign s1_valid_in = req_accept || (s1_valid_ff && !s1_advance);

   always_ff @(posedge clock) begin
      if (reset) s1_valid_ff <= 1'b0;
      else       s1_valid_ff <= s1_valid_in;
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_mode_ff     <= req_tuser;
         s1_idx_ff      <= req_idx;
         s1_in_range_ff <= ({1'b0, req_key} < (KEY_W + 1)'(KEY_COUNT));
         s1_now_ff      <= req_now;
         s1_wdb_ff      <= req_tdata[41];
         s1_rel_ff      <= req_tdata[42];
         s1_excl_ff     <= req_tdata[43];
      end
   end

   // ---------------- entry update ----------------
   logic [TIME_W-1:0] elapsed;
   logic              below_max, above_long, below_recent;
   logic              q_down, q_long, q_jp, q_jr;
   entry_type         new_entry;

   assign elapsed      = s1_now_ff - rd_entry_ff.stamp;
   assign below_max    = elapsed < {16'd0, max_down_ff};
   assign above_long   = elapsed > {16'd0, long_down_ff};
   assign below_recent = elapsed < {16'd0, recent_win_ff};

   always_comb begin
      q_down    = 1'b0;
      q_long    = 1'b0;
      q_jp      = 1'b0;
      q_jr      = 1'b0;
      new_entry = rd_entry_ff;
      if (s1_in_range_ff) begin
         case (s1_mode_ff)
            MODE_KEY_MSG: begin
               new_entry.stamp    = s1_now_ff;
               new_entry.was_down = s1_wdb_ff;
               new_entry.released = s1_rel_ff;
               if (s1_rel_ff) new_entry.latch = 1'b0;
            end
            MODE_QUERY: begin
               q_down = below_max && !rd_entry_ff.released;
               q_long = above_long && q_down;
            end
            MODE_JUST_PRESS: begin
               q_jp = below_recent && !rd_entry_ff.released &&
                      !rd_entry_ff.was_down && !rd_entry_ff.latch;
               if (q_jp) new_entry.latch = 1'b1;
            end
            MODE_JUST_REL: begin
               q_jr = below_recent && rd_entry_ff.released;
               if (q_jr && s1_excl_ff) new_entry = '0;
            end
            MODE_CLEAR: new_entry = '0;
            default: ;  // unused codes leave the entry alone
         endcase
      end
   end

   // ---------------- table ----------------
   entry_type        mem [KEY_COUNT];
   logic             mem_we;
   logic [IDX_W-1:0] mem_waddr;
   entry_type        mem_wdata;

   always_comb begin
      mem_we    = s1_advance && s1_in_range_ff;
      mem_waddr = s1_idx_ff;
      mem_wdata = new_entry;
      if (clr_busy_ff) begin
         mem_we    = 1'b1;
         mem_waddr = clr_cnt_ff;
         mem_wdata = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) mem[mem_waddr] <= mem_wdata;
      if (req_accept) begin
         // same-cycle write to the same key wins over the stale array copy
         if (mem_we && mem_waddr == req_idx) rd_entry_ff <= mem_wdata;
         else                                 rd_entry_ff <= mem[req_idx];
      end
   end

   // ---------------- response register ----------------
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [RSP_TDATA_W-1:0] rsp_data_ff;

   assign rsp_valid_in = s1_advance || (rsp_valid_ff && !rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) rsp_valid_ff <= 1'b0;
      else       rsp_valid_ff <= rsp_valid_in;
   end

   always_ff @(posedge clock) begin
      if (s1_advance)
         rsp_data_ff <= {3'b000, q_jr, q_jp, q_long, q_down, s1_in_range_ff};
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

`default_nettype wire

>>> hdl/ksq_checker.sv
`default_nettype none

module ksq_checker
   import ksq_pkg::*;
(
   input wire                   clock,
   input wire                   reset,
   input wire                   req_tready,
   input wire                   rsp_tvalid,
   input wire                   rsp_tready,
   input wire [RSP_TDATA_W-1:0] rsp_tdata
);

   // nothing taken or shown right after reset (clearing pass runs)
   a_reset_quiet: assert property (@(posedge clock)
      reset |=> (!req_tready && !rsp_tvalid))
      else $error("request or response active right after reset");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=> (rsp_tvalid && $stable(rsp_tdata)))
      else $error("stalled response changed");

   a_long_implies_down: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (!rsp_tdata[2] || rsp_tdata[1]))
      else $error("long-down without down");

   a_one_query_kind: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> $onehot0({rsp_tdata[1], rsp_tdata[3], rsp_tdata[4]}))
      else $error("flags of different query kinds together");

   a_out_of_range_quiet: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tdata[0]) |-> (rsp_tdata[4:1] == 4'd0))
      else $error("flag set for key outside table");

endmodule

bind key_state_table_qualifier ksq_checker u_ksq_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

`default_nettype wire

>>> bench/key_state_table_qualifier_test.sv
`timescale 1ns / 1ps

module key_state_table_qualifier_test;
   import ksq_pkg::*;

   localparam int TABLE_DEPTH = 256;
   localparam int TBL_IDX_W   = $clog2(TABLE_DEPTH);
   localparam int N_SETTINGS  = 6;
   localparam int SET_IDX_W   = $clog2(N_SETTINGS);
   localparam int PER_PHASE   = 150;
   localparam int LONG_HOLD   = 400;

   // tuser codes the block ignores, and the register index with no register behind it
   localparam logic [MODE_W-1:0]    MODE_UNUSED_LO = 3'd5;
   localparam logic [MODE_W-1:0]    MODE_UNUSED_HI = 3'd7;
   localparam logic [CSR_IDX_W-1:0] REG_SPARE      = 2'd3;

   typedef struct {
      logic [MODE_W-1:0] mode;
      logic [KEY_W-1:0]  key;
      logic [TIME_W-1:0] now;
      logic              wdb;
      logic              rel;
      logic              excl;
   } key_req_type;

   // same bit order as rsp_tdata[4:0]
   typedef struct packed {
      logic jr;
      logic jp;
      logic down_long;
      logic down;
      logic in_range;
   } key_flags_type;

   logic                   clock      = 1'b0;
   logic                   reset      = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [REQ_TDATA_W-1:0] req_tdata  = '0;
   logic [MODE_W-1:0]      req_tuser  = '0;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [RSP_TDATA_W-1:0] rsp_tdata;
   logic                   csr_valid  = 1'b0;
   logic                   csr_ready;
   logic [CSR_IDX_W-1:0]   csr_index  = '0;
   logic [THR_W-1:0]       csr_data   = '0;

   key_state_table_qualifier #(
      .KEY_COUNT(TABLE_DEPTH)
   ) u_dut (
      .clock(clock),
      .reset(reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata(req_tdata),
      .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_index(csr_index),
      .csr_data(csr_data)
   );

   always #10 clock = ~clock;

   // shadow copy of the key table and thresholds
   entry_type        key_table [TABLE_DEPTH];
   logic [THR_W-1:0] thr_max_down = MAX_DOWN_RST;
   logic [THR_W-1:0] thr_long     = LONG_DOWN_RST;
   logic [THR_W-1:0] thr_recent   = RECENT_WIN_RST;

   key_req_type   pend_q[$];      // requests waiting for the driver
   key_flags_type flags_due_q[$]; // flags owed by the block, oldest first
   key_req_type   req_cur;
   logic          req_fire = 1'b0;

   int idle_pct   = 0;
   int src_gap    = 0;
   int sink_gap   = 0;
   int stall_asks = 0;
   int stall_seen = 0;
   int hold_cnt   = 0;

   int n_queued   = 0;
   int n_accepted = 0;
   int n_checked  = 0;
   int n_settings = 1;
   int err_count  = 0;
   int hit_down, hit_long, hit_jp, hit_jr, hit_oor;

   // threshold table per phase; the last phase draws random values
   logic [THR_W-1:0] set_max  [N_SETTINGS] = '{16'd5000, 16'd0, 16'hFFFF, 16'd300, 16'hFFFF, 16'd0};
   logic [THR_W-1:0] set_long [N_SETTINGS] = '{16'd500, 16'd0, 16'hFFFF, 16'd20, 16'd0, 16'd0};
   logic [THR_W-1:0] set_rec  [N_SETTINGS] = '{16'd100, 16'd0, 16'hFFFF, 16'hFFFF, 16'd1, 16'd0};
   int               set_idle [N_SETTINGS] = '{20, 30, 10, 0, 40, 0};

   // Predicts the flags for one request and updates the shadow entry.
   function automatic key_flags_type qualify_request(input key_req_type r);
      key_flags_type     f;
      entry_type         e;
      logic [TIME_W-1:0] elapsed;
      f = '0;
      f.in_range = (r.key < KEY_W'(TABLE_DEPTH));
      if (f.in_range) begin
         e = key_table[r.key[TBL_IDX_W-1:0]];
         elapsed = r.now - e.stamp;   // wraps mod 2^32
         case (r.mode)
            MODE_KEY_MSG: begin
               e.stamp    = r.now;
               e.was_down = r.wdb;
               e.released = r.rel;
               if (r.rel) e.latch = 1'b0;
            end
            MODE_QUERY: begin
               f.down      = (elapsed < {16'h0, thr_max_down}) && !e.released;
               f.down_long = f.down && (elapsed > {16'h0, thr_long});
            end
            MODE_JUST_PRESS: begin
               f.jp = (elapsed < {16'h0, thr_recent}) && !e.released && !e.was_down
                      && !e.latch;
               if (f.jp) e.latch = 1'b1;
            end
            MODE_JUST_REL: begin
               f.jr = (elapsed < {16'h0, thr_recent}) && e.released;
               if (f.jr && r.excl) e = '0;
            end
            MODE_CLEAR: e = '0;
            default: ;
         endcase
         key_table[r.key[TBL_IDX_W-1:0]] = e;
      end
      return f;
   endfunction

   task automatic cmp_flag(input string name, input logic want, input logic got);
      if (want !== got) begin
         $error("%s: expected %0b, got %0b", name, want, got);
         err_count++;
      end
   endtask

   // Request and response monitor. Sampled at the rising edge, before the
   // block's own updates land.
   always @(posedge clock) begin
      key_flags_type want, got;
      if (reset) begin
         req_fire = 1'b0;
      end else begin
         req_fire = req_tvalid && req_tready;
         if (req_fire) begin
            flags_due_q.push_back(qualify_request(req_cur));
            n_accepted++;
         end
         if (rsp_tvalid && rsp_tready) begin
            got = rsp_tdata[4:0];
            if (flags_due_q.size() == 0) begin
               $error("response 0x%02h with no request outstanding", rsp_tdata);
               err_count++;
            end else begin
               want = flags_due_q.pop_front();
               cmp_flag("key_in_range", want.in_range, got.in_range);
               cmp_flag("key_down", want.down, got.down);
               cmp_flag("key_down_long", want.down_long, got.down_long);
               cmp_flag("just_pressed", want.jp, got.jp);
               cmp_flag("just_released", want.jr, got.jr);
               n_checked++;
               hit_down += int'(want.down);
               hit_long += int'(want.down_long);
               hit_jp   += int'(want.jp);
               hit_jr   += int'(want.jr);
               hit_oor  += int'(!want.in_range);
            end
         end
      end
   end

   // Request driver: holds a request until taken, then maybe idles a burst.
   always @(negedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (req_tvalid && !req_fire) begin
         // still waiting on tready
      end else if (src_gap > 0) begin
         src_gap--;
         req_tvalid <= 1'b0;
      end else if (pend_q.size() != 0) begin
         req_cur = pend_q.pop_front();
         req_tuser  <= req_cur.mode;
         req_tdata  <= {4'h0, req_cur.excl, req_cur.rel, req_cur.wdb, req_cur.now,
                        req_cur.key};
         req_tvalid <= 1'b1;
         if ($urandom_range(0, 99) < idle_pct) src_gap = $urandom_range(1, 5);
      end else begin
         req_tvalid <= 1'b0;
      end
   end

   // Response sink: random stall bursts, plus a long hold-off on request so
   // the pipeline backs up into req_tready.
   always @(negedge clock) begin
      if (stall_seen != stall_asks) begin
         stall_seen = stall_asks;
         hold_cnt   = LONG_HOLD;
      end
      if (hold_cnt > 0) begin
         hold_cnt--;
         rsp_tready <= 1'b0;
      end else if (sink_gap > 0) begin
         sink_gap--;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
         if ($urandom_range(0, 99) < idle_pct) sink_gap = $urandom_range(1, 5);
      end
   end

   // random single-bit flag
   function automatic logic coin();
      return 1'($urandom_range(0, 1));
   endfunction

   task automatic add_req(input logic [MODE_W-1:0] mode, input logic [KEY_W-1:0] key,
                          input logic [TIME_W-1:0] now, input logic wdb, input logic rel,
                          input logic excl);
      key_req_type r;
      r.mode = mode;
      r.key  = key;
      r.now  = now;
      r.wdb  = wdb;
      r.rel  = rel;
      r.excl = excl;
      pend_q.push_back(r);
      n_queued++;
   endtask

   task automatic csr_write(input logic [CSR_IDX_W-1:0] idx, input logic [THR_W-1:0] val);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         REG_MAX_DOWN:   thr_max_down = val;
         REG_LONG_DOWN:  thr_long     = val;
         REG_RECENT_WIN: thr_recent   = val;
         default: ;
      endcase
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // every request sent, every response back
   task automatic wait_drained();
      do @(posedge clock);
      while (pend_q.size() != 0 || req_tvalid || flags_due_q.size() != 0);
   endtask

   // elapsed time clustered around a threshold, with the odd wide one
   function automatic logic [TIME_W-1:0] pick_elapsed(input logic [THR_W-1:0] thr);
      logic [TIME_W-1:0] t;
      t = {16'h0, thr};
      case ($urandom_range(0, 5))
         0: return '0;
         1: return t - 32'd1;
         2: return t;
         3: return t + 32'd1;
         4: return $urandom_range(0, t * 2 + 2);
         default: return $urandom;
      endcase
   endfunction

   // mostly a handful of hot keys so entries get revisited
   function automatic logic [KEY_W-1:0] pick_key();
      int sel;
      sel = $urandom_range(0, 9);
      if (sel < 7) return KEY_W'($urandom_range(0, 7));
      else if (sel < 9) return KEY_W'($urandom_range(0, TABLE_DEPTH - 1));
      else return KEY_W'(TABLE_DEPTH - 1);
   endfunction

   // press message, a few queries near the thresholds, maybe a release, rarely a clear
   task automatic key_session();
      logic [KEY_W-1:0]  k;
      logic [TIME_W-1:0] t;
      int                n;
      k = pick_key();
      t = $urandom;
      add_req(MODE_KEY_MSG, k, t, $urandom_range(0, 3) == 0, $urandom_range(0, 4) == 0,
              coin());
      n = $urandom_range(1, 4);
      repeat (n) begin
         case ($urandom_range(0, 2))
            0: add_req(MODE_QUERY, k,
                       t + pick_elapsed(coin() ? thr_max_down : thr_long),
                       coin(), coin(), coin());
            1: add_req(MODE_JUST_PRESS, k, t + pick_elapsed(thr_recent),
                       coin(), coin(), coin());
            default: add_req(MODE_JUST_REL, k, t + pick_elapsed(thr_recent),
                             coin(), coin(), coin());
         endcase
      end
      if (coin()) begin
         t = t + pick_elapsed(thr_long);
         add_req(MODE_KEY_MSG, k, t, coin(), 1'b1, coin());
         n = $urandom_range(1, 2);
         repeat (n)
            add_req(MODE_JUST_REL, k, t + pick_elapsed(thr_recent), coin(), coin(), coin());
         if (coin())
            add_req(MODE_QUERY, k, t + pick_elapsed(thr_max_down), coin(), coin(), coin());
      end
      if ($urandom_range(0, 9) == 0)
         add_req(MODE_CLEAR, k, $urandom, coin(), coin(), coin());
   endtask

   task automatic queue_directed();
      add_req(MODE_QUERY,      9'd5, 32'd50, 1'b0, 1'b0, 1'b0);   // unwritten entry counts down
      add_req(MODE_JUST_PRESS, 9'd5, 32'd99, 1'b0, 1'b0, 1'b0);   // fires, sets latch
      add_req(MODE_JUST_PRESS, 9'd5, 32'd10, 1'b0, 1'b0, 1'b0);   // latch blocks it
      add_req(MODE_KEY_MSG,    9'd5, 32'hFFFF_FFF0, 1'b0, 1'b0, 1'b0); // stamp just before wrap
      add_req(MODE_QUERY,      9'd5, 32'h0000_0100, 1'b0, 1'b0, 1'b0); // elapsed 272 across wrap
      add_req(MODE_QUERY,      9'd5, 32'd485, 1'b0, 1'b0, 1'b0);  // elapsed 501, long press
      add_req(MODE_QUERY,      9'd5, 32'd4984, 1'b0, 1'b0, 1'b0); // elapsed 5000, not down
      add_req(MODE_JUST_PRESS, 9'd5, 32'd83, 1'b0, 1'b0, 1'b0);   // press msg keeps the latch
      add_req(MODE_KEY_MSG,    9'd5, 32'd1000, 1'b0, 1'b1, 1'b0); // release clears latch
      add_req(MODE_JUST_REL,   9'd5, 32'd1099, 1'b0, 1'b0, 1'b0); // last tick in window
      add_req(MODE_JUST_REL,   9'd5, 32'd1100, 1'b0, 1'b0, 1'b0); // window edge, no fire
      add_req(MODE_JUST_REL,   9'd5, 32'd1050, 1'b0, 1'b0, 1'b1); // exclusive wipes entry
      add_req(MODE_QUERY,      9'd5, 32'd10, 1'b0, 1'b0, 1'b0);
      add_req(MODE_KEY_MSG,    9'd6, 32'd2000, 1'b1, 1'b0, 1'b0);
      add_req(MODE_JUST_PRESS, 9'd6, 32'd2010, 1'b0, 1'b0, 1'b0); // was already down
      add_req(MODE_KEY_MSG,    9'd255, 32'hFFFF_FFFF, 1'b1, 1'b1, 1'b1);
      add_req(MODE_CLEAR,      9'd255, 32'd1234, 1'b1, 1'b1, 1'b1);
      add_req(MODE_QUERY,      9'd255, 32'd0, 1'b0, 1'b0, 1'b0);
      // keys past the table end
      add_req(MODE_KEY_MSG,    9'd256, 32'd77, 1'b1, 1'b1, 1'b1);
      add_req(MODE_QUERY,      9'd511, 32'hFFFF_FFFF, 1'b0, 1'b0, 1'b0);
      add_req(MODE_JUST_PRESS, 9'd300, 32'd0, 1'b0, 1'b0, 1'b0);
      // unused tuser codes must leave key 7 alone
      add_req(MODE_UNUSED_LO,  9'd7, 32'd0, 1'b1, 1'b1, 1'b1);
      add_req(MODE_UNUSED_HI,  9'd7, 32'hFFFF_FFFF, 1'b1, 1'b1, 1'b1);
      add_req(MODE_QUERY,      9'd7, 32'd0, 1'b0, 1'b0, 1'b0);
      add_req(MODE_KEY_MSG,    9'd0, 32'd0, 1'b1, 1'b1, 1'b1);
   endtask

   initial begin
      int ph;
      int phase_end;
      foreach (key_table[i]) key_table[i] = '0;
      hit_down = 0;
      hit_long = 0;
      hit_jp   = 0;
      hit_jr   = 0;
      hit_oor  = 0;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      for (ph = 0; ph < N_SETTINGS; ph++) begin
         if (ph == 0) begin
            // reset thresholds; block may still be in its clearing pass
            idle_pct = set_idle[SET_IDX_W'(ph)];
            queue_directed();
         end else begin
            wait_drained();   // sender pauses until all responses are in
            idle_pct = set_idle[SET_IDX_W'(ph)];
            if (ph == N_SETTINGS - 1) begin
               set_max[SET_IDX_W'(ph)]  = THR_W'($urandom);
               set_long[SET_IDX_W'(ph)] = THR_W'($urandom);
               set_rec[SET_IDX_W'(ph)]  = THR_W'($urandom);
            end
            if (ph == 1) csr_write(REG_SPARE, THR_W'($urandom));
            csr_write(REG_MAX_DOWN, set_max[SET_IDX_W'(ph)]);
            csr_write(REG_LONG_DOWN, set_long[SET_IDX_W'(ph)]);
            csr_write(REG_RECENT_WIN, set_rec[SET_IDX_W'(ph)]);
            n_settings++;
         end
         phase_end = (ph + 1) * PER_PHASE;
         while (n_queued < phase_end) begin
            if ($urandom_range(0, 9) < 8)
               key_session();
            else
               add_req(MODE_W'($urandom_range(0, 7)), KEY_W'($urandom_range(0, 511)),
                       $urandom, coin(), coin(), coin());
         end
         // sink holds off while plenty of requests are still queued
         if (ph == 2) stall_asks++;
      end

      wait_drained();
      repeat (8) @(posedge clock);
      $display("covered %0d requests / %0d responses over %0d threshold settings",
               n_accepted, n_checked, n_settings);
      $display("hits: down %0d, long %0d, just pressed %0d, just released %0d, off table %0d",
               hit_down, hit_long, hit_jp, hit_jr, hit_oor);
      if (err_count == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

   initial begin
      #5_000_000;
      $display("timeout with %0d responses outstanding", flags_due_q.size());
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule

>>> key_state_table_qualifier.f
hdl/ksq_pkg.sv
hdl/key_state_table_qualifier.sv
hdl/ksq_checker.sv
bench/key_state_table_qualifier_test.sv
